// File: sv/acl_pkg.sv
// Shared types and constants for the associative slot cache.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package acl_pkg;

  localparam int ENTRIES   = 8;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int KEY_W     = 64;
  localparam int HDL_W     = 32;
  localparam int STAMP_W   = 32;
  localparam int SLOT_W    = 3;
  localparam int LFSR_W    = 16;
  localparam int EXT_W     = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  // operation codes on the input tuser
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // replacement policy codes
  localparam logic POL_LRU    = 1'b0;
  localparam logic POL_RANDOM = 1'b1;

  localparam int S_TDATA_W = KEY_W + HDL_W + STAMP_W;
  localparam int M_RAW_W   = HDL_W + HDL_W + SLOT_W;
  localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [HDL_W-1:0]   handle;
    logic [KEY_W-1:0]   key;
  } slot_ent_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] idx;
  } rand_res_t;

  typedef struct packed {
    logic key_eq;
    logic stamp_lt;
  } cmp_res_t;

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [EXT_W-1:0] t;
    t = EXT_W'(idx);
    return t[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: sv/acl_slot_ram.sv
// Slot storage: key, handle and stamp per slot, one write and one read port.
// Read data is registered. Depends on acl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module acl_slot_ram (
  input  wire                        clk_i,
  input  wire                        we_i,
  input  wire [acl_pkg::IDX_W-1:0]   waddr_i,
  input  acl_pkg::slot_ent_t         wdata_i,
  input  wire [acl_pkg::IDX_W-1:0]   raddr_i,
  output acl_pkg::slot_ent_t         rdata_o
);

  acl_pkg::slot_ent_t mem [acl_pkg::ENTRIES];
  acl_pkg::slot_ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: sv/acl_cmp.sv
// Shared slot compare unit: key equality and unsigned stamp less-than.
// Depends on acl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module acl_cmp (
  input  wire [acl_pkg::KEY_W-1:0]   key_a_i,
  input  wire [acl_pkg::KEY_W-1:0]   key_b_i,
  input  wire [acl_pkg::STAMP_W-1:0] stamp_a_i,
  input  wire [acl_pkg::STAMP_W-1:0] stamp_b_i,
  output acl_pkg::cmp_res_t          res_o
);

  assign res_o.key_eq   = (key_a_i == key_b_i);
  assign res_o.stamp_lt = (stamp_a_i < stamp_b_i);

endmodule
`default_nettype wire

// File: sv/acl_rand.sv
// Random victim source: Galois LFSR stepped on start; the victim is the new
// value modulo ENTRIES (a power of two, so a mask). Depends on acl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module acl_rand (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  output acl_pkg::rand_res_t res_o
);

  logic [acl_pkg::LFSR_W-1:0] lfsr_q, lfsr_d;
  logic                       done_q, done_d;

  always_comb begin
    lfsr_d = lfsr_q;
    done_d = 1'b0;
    if (start_i) begin
      lfsr_d = acl_pkg::lfsr_next(lfsr_q);
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= acl_pkg::LFSR_SEED;
      done_q <= 1'b0;
    end else begin
      lfsr_q <= lfsr_d;
      done_q <= done_d;
    end
  end

  assign res_o.done = done_q;
  assign res_o.idx  = acl_pkg::IDX_W'(lfsr_q % acl_pkg::LFSR_W'(acl_pkg::ENTRIES));

endmodule
`default_nettype wire

// File: sv/assoc_cache_lru_random.sv
// Fully associative slot cache, LRU or random replacement; top level.
// A lookup ends early on a hit, an insert on a free slot; a random victim adds
//   the RAND, RDV and RDW states before the write.
// Throughput: one item at a time; the single slot RAM read port and compare unit
//   visit one slot per cycle while scanning, and an output stall holds the next item.
// Reset: rst_ni async low; all slots empty, LFSR at 0xACE1, policy LRU.
`timescale 1ns / 1ps
`default_nettype none
module assoc_cache_lru_random (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // configuration: policy register
  input  wire                             cfg_we_i,
  input  wire                             cfg_wdata_i,
  // request stream
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire [acl_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // key, handle, now
  input  wire                             s_axis_tuser,  // func
  // result stream
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [acl_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // found_handle, evicted_handle,
                                                         // slot, zero pad
  output logic [1:0]                      m_axis_tuser   // hit, evicted
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;  // walk slots through the compare unit
  localparam logic [2:0] ST_RAND = 3'd2;  // wait for random victim
  localparam logic [2:0] ST_RDV  = 3'd3;  // read victim slot
  localparam logic [2:0] ST_RDW  = 3'd4;  // victim handle available
  localparam logic [2:0] ST_WR   = 3'd5;  // write inserted entry
  localparam logic [2:0] ST_DONE = 3'd6;  // hand result to output register

  localparam int IW = acl_pkg::IDX_W;

  logic [2:0]                   state_q, state_d;
  logic [IW:0]                  idx_q, idx_d;        // next slot to read
  logic                         chk_vld_q, chk_vld_d;
  logic [IW-1:0]                chk_idx_q, chk_idx_d; // slot whose data is on rd_ent
  logic [acl_pkg::ENTRIES-1:0]  valid_q, valid_d;
  logic                         policy_q;

  // request, held for the whole item
  logic                         func_q;
  logic [acl_pkg::KEY_W-1:0]    key_q;
  logic [acl_pkg::HDL_W-1:0]    handle_q;
  logic [acl_pkg::STAMP_W-1:0]  now_q;

  // LRU tracking and target
  logic [IW-1:0]                best_idx_q, best_idx_d;
  logic [acl_pkg::STAMP_W-1:0]  best_stamp_q, best_stamp_d;
  logic [acl_pkg::HDL_W-1:0]    best_hdl_q, best_hdl_d;
  logic [IW-1:0]                tgt_q, tgt_d;

  // result fields under construction
  logic                         r_hit_q, r_hit_d;
  logic [acl_pkg::HDL_W-1:0]    r_fh_q, r_fh_d;
  logic                         r_ev_q, r_ev_d;
  logic [acl_pkg::HDL_W-1:0]    r_evh_q, r_evh_d;
  logic [IW-1:0]                r_slot_q, r_slot_d;

  // output register
  logic                         m_vld_q, m_vld_d;
  logic [acl_pkg::M_TDATA_W-1:0] m_data_q;
  logic [1:0]                   m_user_q;
  logic                         m_load;

  // RAM and shared units
  logic                         ram_we;
  logic [IW-1:0]                ram_waddr;
  acl_pkg::slot_ent_t           ram_wdata;
  logic [IW-1:0]                ram_raddr;
  acl_pkg::slot_ent_t           rd_ent;
  acl_pkg::cmp_res_t            cmp;
  logic [acl_pkg::STAMP_W-1:0]  cmp_stamp_b;
  logic                         rand_start;
  acl_pkg::rand_res_t           rand_res;

  logic                         s_acc;
  logic                         issue;
  logic                         last;
  logic                         slot_v;
  logic                         better;
  logic [IW-1:0]                nb_idx;
  logic [acl_pkg::HDL_W-1:0]    nb_hdl;

  acl_slot_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_ent)
  );

  // stamp side compares the slot just read against the running minimum
  assign cmp_stamp_b = best_stamp_q;

  acl_cmp u_cmp (
    .key_a_i   (rd_ent.key),
    .key_b_i   (key_q),
    .stamp_a_i (rd_ent.stamp),
    .stamp_b_i (cmp_stamp_b),
    .res_o     (cmp)
  );

  acl_rand u_rand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rand_start),
    .res_o   (rand_res)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign issue         = (idx_q < (IW+1)'(acl_pkg::ENTRIES));
  assign last          = (chk_idx_q == IW'(acl_pkg::ENTRIES - 1));
  assign slot_v        = valid_q[chk_idx_q];
  // strict less-than keeps the lowest index among equal stamps
  assign better        = (chk_idx_q == '0) || cmp.stamp_lt;
  assign nb_idx        = better ? chk_idx_q : best_idx_q;
  assign nb_hdl        = better ? rd_ent.handle : best_hdl_q;
  assign m_load        = (state_q == ST_DONE) && (!m_vld_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    valid_d      = valid_q;
    best_idx_d   = best_idx_q;
    best_stamp_d = best_stamp_q;
    best_hdl_d   = best_hdl_q;
    tgt_d        = tgt_q;
    r_hit_d      = r_hit_q;
    r_fh_d       = r_fh_q;
    r_ev_d       = r_ev_q;
    r_evh_d      = r_evh_q;
    r_slot_d     = r_slot_q;
    ram_we       = 1'b0;
    ram_waddr    = tgt_q;
    ram_wdata    = '{stamp: now_q, handle: handle_q, key: key_q};
    ram_raddr    = idx_q[IW-1:0];
    rand_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          idx_d    = '0;
          r_hit_d  = 1'b0;
          r_fh_d   = '0;
          r_ev_d   = 1'b0;
          r_evh_d  = '0;
          r_slot_d = '0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read of slot idx_q is issued while slot chk_idx_q is evaluated
        if (issue) begin
          idx_d     = idx_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = idx_q[IW-1:0];
        end
        if (chk_vld_q) begin
          if (func_q == acl_pkg::FUNC_LOOKUP) begin
            if (slot_v && cmp.key_eq) begin
              // hit: refresh the stamp, keep key and handle
              r_hit_d   = 1'b1;
              r_fh_d    = rd_ent.handle;
              r_slot_d  = chk_idx_q;
              ram_we    = 1'b1;
              ram_waddr = chk_idx_q;
              ram_wdata = '{stamp: now_q, handle: rd_ent.handle, key: rd_ent.key};
              state_d   = ST_DONE;
            end else if (last) begin
              state_d = ST_DONE;
            end
          end else begin
            if (!slot_v) begin
              tgt_d   = chk_idx_q;
              state_d = ST_WR;
            end else begin
              best_idx_d = nb_idx;
              best_hdl_d = nb_hdl;
              if (better) begin
                best_stamp_d = rd_ent.stamp;
              end
              if (last) begin
                // cache full: a valid entry gets displaced
                r_ev_d = 1'b1;
                if (policy_q == acl_pkg::POL_RANDOM) begin
                  rand_start = 1'b1;
                  state_d    = ST_RAND;
                end else begin
                  tgt_d   = nb_idx;
                  r_evh_d = nb_hdl;
                  state_d = ST_WR;
                end
              end
            end
          end
        end
      end
      ST_RAND: begin
        if (rand_res.done) begin
          tgt_d   = rand_res.idx;
          state_d = ST_RDV;
        end
      end
      ST_RDV: begin
        ram_raddr = tgt_q;
        state_d   = ST_RDW;
      end
      ST_RDW: begin
        r_evh_d = rd_ent.handle;
        state_d = ST_WR;
      end
      ST_WR: begin
        ram_we         = 1'b1;
        ram_waddr      = tgt_q;
        valid_d[tgt_q] = 1'b1;
        r_slot_d       = tgt_q;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (m_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_vld_d = m_vld_q;
    if (m_vld_q && m_axis_tready) begin
      m_vld_d = 1'b0;
    end
    if (m_load) begin
      m_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      chk_vld_q <= 1'b0;
      valid_q   <= '0;
      policy_q  <= acl_pkg::POL_LRU;
      m_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      chk_vld_q <= chk_vld_d;
      valid_q   <= valid_d;
      m_vld_q   <= m_vld_d;
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      func_q   <= s_axis_tuser;
      key_q    <= s_axis_tdata[acl_pkg::KEY_W-1:0];
      handle_q <= s_axis_tdata[acl_pkg::KEY_W +: acl_pkg::HDL_W];
      now_q    <= s_axis_tdata[acl_pkg::KEY_W + acl_pkg::HDL_W +: acl_pkg::STAMP_W];
    end
    chk_idx_q    <= chk_idx_d;
    best_idx_q   <= best_idx_d;
    best_stamp_q <= best_stamp_d;
    best_hdl_q   <= best_hdl_d;
    tgt_q        <= tgt_d;
    r_hit_q      <= r_hit_d;
    r_fh_q       <= r_fh_d;
    r_ev_q       <= r_ev_d;
    r_evh_q      <= r_evh_d;
    r_slot_q     <= r_slot_d;
    if (m_load) begin
      m_data_q <= acl_pkg::M_TDATA_W'({acl_pkg::to_slot(r_slot_q), r_evh_q, r_fh_q});
      m_user_q <= {r_ev_q, r_hit_q};
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
`default_nettype wire

// File: sv/acl_checker.sv
// Port-level checks for the slot cache, bound to the top level.
// Depends on acl_pkg and assoc_cache_lru_random.
`timescale 1ns / 1ps
`default_nettype none
module acl_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             s_axis_tvalid,
  input wire                             s_axis_tready,
  input wire                             m_axis_tvalid,
  input wire                             m_axis_tready,
  input wire [acl_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input wire [1:0]                       m_axis_tuser
);

  // one item at a time: intake closes right after a transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // a result never carries both a lookup hit and an eviction
  a_hit_ev_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("hit and evicted both set");

  // handle fields read as zero when their flag is clear
  a_zero_handles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser[0] || m_axis_tdata[31:0] == '0) &&
      (m_axis_tuser[1] || m_axis_tdata[63:32] == '0))
    else $error("handle nonzero without its flag");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed under stall");

endmodule

bind assoc_cache_lru_random acl_checker u_acl_checker (.*);
`default_nettype wire
